FILE: rtl/core/lflm_pkg.sv
// ----------------------------------------------------------------------------
// Slot manager package
// Shared widths, command codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package lflm_pkg;

    localparam int CMD_W         = 2;
    localparam int IDX_W         = 4;
    localparam int DEF_NUM_SLOTS = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic clear;   // write one entry of the link table reset sweep
        logic accept;  // latch the command and read the link table
        logic exec;    // apply the command and load the result register
        logic link;    // append write to the old tail entry
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic need_link;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/core/lflm_cmd_if.sv
// ----------------------------------------------------------------------------
// Slot manager command channel
// Valid/ready channel that carries one command transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lflm_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [lflm_pkg::CMD_W-1:0] command;
    logic [lflm_pkg::IDX_W-1:0] slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lflm_rsp_if.sv
// ----------------------------------------------------------------------------
// Slot manager response channel
// Valid/ready channel that carries one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lflm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [lflm_pkg::IDX_W-1:0] result_index;
    logic                      ok;

    modport source (output valid, output result_index, output ok, input ready);
    modport sink   (input valid, input result_index, input ok, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/linked_free_list_fifo_manager_core.sv
// Result: a command is latched when accepted, and its result is loaded in the
// execute step, which waits until the previous result has been taken.
// Commands: a new command is taken only after the last one is done; an enqueue
// onto a non-empty queue adds a link step, as the link table has one write port.
// Reset: a sweep writes every entry of the link table to rebuild it; commands are
// refused (ready low) until it ends.
// ----------------------------------------------------------------------------
// Slot manager top level
// Free list and linked FIFO of slot indices sharing one link table.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_free_list_fifo_manager_core #(
    parameter int NUM_SLOTS = lflm_pkg::DEF_NUM_SLOTS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lflm_cmd_if.sink    i_cmd,
    lflm_rsp_if.source  o_rsp
);

    lflm_pkg::t_dp_ctrl   s_ctrl;
    lflm_pkg::t_dp_status s_status;

    lflm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_ctrl      (s_ctrl),
        .i_status    (s_status)
    );

    lflm_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (s_ctrl),
        .o_status       (s_status),
        .i_command      (lflm_pkg::t_cmd'(i_cmd.command)),
        .i_slot_index   (i_cmd.slot_index),
        .o_result_index (o_rsp.result_index),
        .o_ok           (o_rsp.ok)
    );

`ifndef SYNTHESIS
    // Only one link table operation may be in flight in a cycle.
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_ctrl.clear, s_ctrl.accept, s_ctrl.exec, s_ctrl.link}))
        else $error("more than one datapath strobe active");

    // A command is held alone until its result has been produced.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("second command accepted while one is in flight");

    // A new result only appears after an execute step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !$past(o_rsp.valid && !o_rsp.ready)) |-> $past(s_ctrl.exec))
        else $error("result loaded without an execute step");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lflm_dp.sv
// ----------------------------------------------------------------------------
// Slot manager datapath
// Link table memory, list head and tail registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lflm_dp #(
    parameter int NUM_SLOTS = lflm_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lflm_pkg::t_dp_ctrl         i_ctrl,
    output lflm_pkg::t_dp_status            o_status,
    input  wire lflm_pkg::t_cmd             i_command,
    input  wire logic [lflm_pkg::IDX_W-1:0] i_slot_index,
    output logic [lflm_pkg::IDX_W-1:0]      o_result_index,
    output logic                            o_ok
);

    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = (LW > lflm_pkg::IDX_W) ? LW : lflm_pkg::IDX_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SLOTS - 1);

    logic [LW-1:0] r_link [NUM_SLOTS];

    logic [LW-1:0]              r_free_head, n_free_head;
    logic [LW-1:0]              r_queue_head, n_queue_head;
    logic [LW-1:0]              r_queue_tail, n_queue_tail;
    logic [AW-1:0]              r_clr_cnt;
    lflm_pkg::t_cmd             r_cmd;
    logic [lflm_pkg::IDX_W-1:0] r_idx;
    logic [LW-1:0]              r_rd_data;
    logic [AW-1:0]              r_pend_addr;
    logic [lflm_pkg::IDX_W-1:0] r_res_index, n_res_index;
    logic                       r_res_ok, n_res_ok;

    logic          free_ok, head_ok, tail_ok, idx_ok, need_link;
    logic [CW-1:0] idx_wide;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    assign free_ok  = r_free_head < NULL_LINK;
    assign head_ok  = r_queue_head < NULL_LINK;
    assign tail_ok  = r_queue_tail < NULL_LINK;
    assign idx_wide = CW'(r_idx);
    assign idx_ok   = idx_wide < CW'(NUM_SLOTS);

    // Dequeue follows the queue head; every other command follows the free list.
    assign rd_addr = (i_command == lflm_pkg::CMD_DEQUEUE) ? r_queue_head[AW-1:0]
                                                          : r_free_head[AW-1:0];

    always_comb begin
        n_free_head  = r_free_head;
        n_queue_head = r_queue_head;
        n_queue_tail = r_queue_tail;
        n_res_index  = '0;
        n_res_ok     = 1'b0;
        need_link    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_clr_cnt;
        wr_data      = LW'(r_clr_cnt) + LW'(1);
        if (i_ctrl.clear) begin
            wr_en = 1'b1;
        end else if (i_ctrl.link) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_addr;
            wr_data = r_queue_tail;
        end else if (i_ctrl.exec) begin
            case (r_cmd)
                lflm_pkg::CMD_ALLOC: begin
                    if (free_ok) begin
                        n_free_head = r_rd_data;
                        n_res_index = lflm_pkg::IDX_W'(r_free_head);
                        n_res_ok    = 1'b1;
                    end
                end
                lflm_pkg::CMD_ENQUEUE: begin
                    if (free_ok) begin
                        n_free_head  = r_rd_data;
                        wr_en        = 1'b1;
                        wr_addr      = r_free_head[AW-1:0];
                        wr_data      = NULL_LINK;
                        if (!head_ok) begin
                            n_queue_head = r_free_head;
                        end
                        need_link    = head_ok && tail_ok;
                        n_queue_tail = r_free_head;
                        n_res_index  = lflm_pkg::IDX_W'(r_free_head);
                        n_res_ok     = 1'b1;
                    end
                end
                lflm_pkg::CMD_DEQUEUE: begin
                    if (head_ok) begin
                        n_queue_head = r_rd_data;
                        n_res_index  = lflm_pkg::IDX_W'(r_queue_head);
                        n_res_ok     = 1'b1;
                    end
                end
                default: begin
                    n_res_index = r_idx;
                    if (idx_ok) begin
                        wr_en       = 1'b1;
                        wr_addr     = AW'(idx_wide);
                        wr_data     = r_free_head;
                        n_free_head = LW'(idx_wide);
                        n_res_ok    = 1'b1;
                    end
                end
            endcase
        end
    end

    // Link table: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link[wr_addr] <= wr_data;
        end
        if (i_ctrl.accept) begin
            r_rd_data <= r_link[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= '0;
            r_queue_head <= NULL_LINK;
            r_queue_tail <= NULL_LINK;
            r_clr_cnt    <= '0;
        end else begin
            r_free_head  <= n_free_head;
            r_queue_head <= n_queue_head;
            r_queue_tail <= n_queue_tail;
            if (i_ctrl.clear && (r_clr_cnt != LAST_ADDR)) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd <= i_command;
            r_idx <= i_slot_index;
        end
        if (i_ctrl.exec) begin
            // The old tail still has to point at the new entry.
            r_pend_addr <= r_queue_tail[AW-1:0];
            r_res_index <= n_res_index;
            r_res_ok    <= n_res_ok;
        end
    end

    assign o_status.clear_done = r_clr_cnt == LAST_ADDR;
    assign o_status.need_link  = need_link;
    assign o_result_index      = r_res_index;
    assign o_ok                = r_res_ok;

endmodule

`default_nettype wire

FILE: rtl/core/lflm_ctrl.sv
// ----------------------------------------------------------------------------
// Slot manager controller
// Sequences the reset sweep, command acceptance, execution and tail append.
// ----------------------------------------------------------------------------
`default_nettype none

module lflm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output lflm_pkg::t_dp_ctrl        o_ctrl,
    input  wire lflm_pkg::t_dp_status i_status
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LINK
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_ctrl.clear  = r_state == ST_CLEAR;
        o_ctrl.accept = (r_state == ST_IDLE) && i_in_valid;
        o_ctrl.exec   = (r_state == ST_EXEC) && out_free;
        o_ctrl.link   = r_state == ST_LINK;

        n_state     = r_state;
        n_ready     = r_ready;
        n_out_valid = o_ctrl.exec || (r_out_valid && !i_out_ready);
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                    n_ready = 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                    n_ready = 1'b0;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (i_status.need_link) begin
                        n_state = ST_LINK;
                    end else begin
                        n_state = ST_IDLE;
                        n_ready = 1'b1;
                    end
                end
            end
            ST_LINK: begin
                n_state = ST_IDLE;
                n_ready = 1'b1;
            end
            default: begin
                n_state = ST_CLEAR;
                n_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
